@@ hdl/assert_macros.svh @@
// Assertion helpers for the walker RTL.
// ASSERT_IMPLIES checks a same-cycle implication, ASSERT_NEXT a next-cycle one.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

@@ hdl/ptw_pkg.sv @@
package ptw_pkg;

  localparam int ADDR_W           = 64;
  localparam int PAGE_OFFSET_BITS = 12;
  localparam int LEVELS           = 4;
  localparam int INDEX_BITS       = 9;
  localparam int ENTRY_SHIFT      = 3;  // 8-byte entries
  localparam int LEVEL_W          = $clog2(LEVELS);

  localparam logic [LEVEL_W-1:0] LAST_LEVEL = LEVEL_W'(LEVELS - 1);

  localparam logic [ADDR_W-1:0] MASK_RESET  = 64'h000F_FFFF_FFFF_F000;
  localparam logic [ADDR_W-1:0] PRESENT_BIT = 64'h1;
  localparam logic [ADDR_W-1:0] LARGE_BIT   = 64'h80;

  typedef enum logic {
    KIND_REQUEST  = 1'b0,
    KIND_RESPONSE = 1'b1
  } item_kind_t;

  typedef enum logic {
    RES_READ = 1'b0,
    RES_DONE = 1'b1
  } result_kind_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_REQ     = 3'd1,
    ST_READ_FAIL   = 3'd2,
    ST_NOT_PRESENT = 3'd3,
    ST_STRAY       = 3'd4
  } status_t;

  // One input transaction as held in the input register
  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] dir_base;
    logic [ADDR_W-1:0] virt_addr;
    logic [ADDR_W-1:0] entry_data;
    logic              read_ok;
  } item_t;

  // Address bits below the index field of a level
  function automatic int level_shift(logic [LEVEL_W-1:0] lvl);
    return PAGE_OFFSET_BITS + INDEX_BITS * (LEVELS - 1 - int'(lvl));
  endfunction

  // Entry address within a table for the given level
  function automatic logic [ADDR_W-1:0] entry_addr(logic [ADDR_W-1:0] base,
                                                   logic [ADDR_W-1:0] va,
                                                   logic [LEVEL_W-1:0] lvl);
    logic [ADDR_W-1:0] sh;
    sh = va >> level_shift(lvl);
    return base + ADDR_W'({sh[INDEX_BITS-1:0], {ENTRY_SHIFT{1'b0}}});
  endfunction

  // Page offset kept for a large page ending at the given level
  function automatic logic [ADDR_W-1:0] page_offset(logic [ADDR_W-1:0] va,
                                                    logic [LEVEL_W-1:0] lvl);
    logic [ADDR_W-1:0] m;
    m = (ADDR_W'(1) << level_shift(lvl)) - ADDR_W'(1);
    return va & m;
  endfunction

endpackage

@@ hdl/ptw_item_if.sv @@
interface ptw_item_if import ptw_pkg::*;;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [ADDR_W-1:0] dir_base;
  logic [ADDR_W-1:0] virt_addr;
  logic [ADDR_W-1:0] entry_data;
  logic              read_ok;

  modport source (output valid, kind, dir_base, virt_addr, entry_data, read_ok,
                  input ready);
  modport sink   (input valid, kind, dir_base, virt_addr, entry_data, read_ok,
                  output ready);
endinterface

@@ hdl/ptw_result_if.sv @@
interface ptw_result_if import ptw_pkg::*;;
  logic              valid;
  logic              ready;
  logic              result_kind;
  logic [ADDR_W-1:0] read_addr;
  logic [ADDR_W-1:0] phys_addr;
  logic [2:0]        status;

  modport source (output valid, result_kind, read_addr, phys_addr, status,
                  input ready);
  modport sink   (input valid, result_kind, read_addr, phys_addr, status,
                  output ready);
endinterface

@@ hdl/ptw_in_stage.sv @@
module ptw_in_stage import ptw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  ptw_item_if.sink   item,
  output logic       stage_valid,
  output item_t      stage_item,
  input  logic       stage_ready
);

  logic valid;
  logic valid_next;
  logic take;

  // Register takes a transaction when empty or when the step stage drains it
  assign item.ready = !valid || stage_ready;
  assign take       = item.valid && item.ready;

  always_comb begin
    valid_next = valid;
    if (take) begin
      valid_next = 1'b1;
    end else if (stage_ready) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  // Payload register
  always_ff @(posedge clk) begin
    if (take) begin
      stage_item.kind       <= item.kind;
      stage_item.dir_base   <= item.dir_base;
      stage_item.virt_addr  <= item.virt_addr;
      stage_item.entry_data <= item.entry_data;
      stage_item.read_ok    <= item.read_ok;
    end
  end

  assign stage_valid = valid;

endmodule

@@ hdl/ptw_step.sv @@
`include "assert_macros.svh"

module ptw_step import ptw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_wdata,
  input  logic              stage_valid,
  input  item_t             stage_item,
  output logic              stage_ready,
  ptw_result_if.source      result
);

  // Walk state
  logic [ADDR_W-1:0]  frame_mask;
  logic               busy;
  logic [LEVEL_W-1:0] level;
  logic [ADDR_W-1:0]  table_base;
  logic [ADDR_W-1:0]  pending_va;

  logic               busy_next;
  logic [LEVEL_W-1:0] level_next;
  logic [ADDR_W-1:0]  table_base_next;
  logic [ADDR_W-1:0]  pending_va_next;

  // Result register
  logic               out_valid;
  logic               res_kind;
  logic [ADDR_W-1:0]  res_read_addr;
  logic [ADDR_W-1:0]  res_phys_addr;
  status_t            res_status;

  logic               res_kind_next;
  logic [ADDR_W-1:0]  res_read_addr_next;
  logic [ADDR_W-1:0]  res_phys_addr_next;
  status_t            res_status_next;

  logic               step;
  logic [ADDR_W-1:0]  base_m;
  logic [ADDR_W-1:0]  frame;
  logic [LEVEL_W-1:0] level_inc;
  logic               large_level;

  assign stage_ready = !out_valid || result.ready;
  assign step        = stage_valid && stage_ready;

  assign base_m      = stage_item.dir_base & frame_mask;
  assign frame       = stage_item.entry_data & frame_mask;
  assign level_inc   = level + LEVEL_W'(1);
  assign large_level = (level != '0) && (level != LAST_LEVEL);

  // One walk step per transaction
  always_comb begin
    busy_next          = busy;
    level_next         = level;
    table_base_next    = table_base;
    pending_va_next    = pending_va;
    res_kind_next      = RES_DONE;
    res_read_addr_next = '0;
    res_phys_addr_next = '0;
    res_status_next    = ST_OK;
    if (stage_item.kind == KIND_REQUEST) begin
      if (stage_item.dir_base == '0 || stage_item.virt_addr == '0) begin
        busy_next       = 1'b0;
        level_next      = '0;
        res_status_next = ST_BAD_REQ;
      end else begin
        busy_next          = 1'b1;
        level_next         = '0;
        table_base_next    = base_m;
        pending_va_next    = stage_item.virt_addr;
        res_kind_next      = RES_READ;
        res_read_addr_next = entry_addr(base_m, stage_item.virt_addr, '0);
      end
    end else if (!busy) begin
      res_status_next = ST_STRAY;
    end else if (!stage_item.read_ok) begin
      busy_next       = 1'b0;
      level_next      = '0;
      res_status_next = ST_READ_FAIL;
    end else if ((stage_item.entry_data & PRESENT_BIT) == '0) begin
      busy_next       = 1'b0;
      level_next      = '0;
      res_status_next = ST_NOT_PRESENT;
    end else if (large_level && (stage_item.entry_data & LARGE_BIT) != '0) begin
      busy_next          = 1'b0;
      level_next         = '0;
      res_phys_addr_next = frame + page_offset(pending_va, level);
    end else if (level == LAST_LEVEL) begin
      busy_next          = 1'b0;
      level_next         = '0;
      res_phys_addr_next = frame + page_offset(pending_va, LAST_LEVEL);
    end else begin
      table_base_next    = frame;
      level_next         = level_inc;
      res_kind_next      = RES_READ;
      res_read_addr_next = entry_addr(frame, pending_va, level_inc);
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_mask <= MASK_RESET;
      busy       <= 1'b0;
      level      <= '0;
      table_base <= '0;
      pending_va <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        frame_mask <= cfg_wdata;
      end
      if (step) begin
        busy       <= busy_next;
        level      <= level_next;
        table_base <= table_base_next;
        pending_va <= pending_va_next;
      end
      if (stage_ready) begin
        out_valid <= stage_valid;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (step) begin
      res_kind      <= res_kind_next;
      res_read_addr <= res_read_addr_next;
      res_phys_addr <= res_phys_addr_next;
      res_status    <= res_status_next;
    end
  end

  assign result.valid       = out_valid;
  assign result.result_kind = res_kind;
  assign result.read_addr   = res_read_addr;
  assign result.phys_addr   = res_phys_addr;
  assign result.status      = res_status;

  // A deeper level only exists inside a walk
  `ASSERT_IMPLIES(a_level_needs_busy, clk, rst, level != '0, busy, "level set while idle")
  // A read request leaves the walker busy
  `ASSERT_NEXT(a_read_sets_busy, clk, rst, step && res_kind_next == RES_READ, busy, "read issued but walker idle")
  // Only a successful finish carries a physical address
  `ASSERT_IMPLIES(a_fail_no_phys, clk, rst, out_valid && res_status != ST_OK, res_phys_addr == '0, "failed walk with nonzero address")
  // Read requests never carry an error status
  `ASSERT_IMPLIES(a_read_ok_status, clk, rst, out_valid && res_kind == RES_READ, res_status == ST_OK, "read request with error status")

endmodule

@@ hdl/four_level_page_table_walker_core.sv @@
// Four-level page table walker. Requests (kind 0) and table-entry read
// responses (kind 1) share the item channel; every transaction accepted
// produces exactly one result transaction: either the next 8-byte entry read
// address or a finished translation with its status. One transaction is
// accepted per clock cycle when the result side keeps up. An accepted
// transaction is held in the input register; the walk-step stage loads its
// result into the result register, from where it is offered. That stage
// reads and updates the walk state (level, table base, pending virtual
// address) once per transaction, so back-to-back transactions see each other
// in order. The frame mask is written through cfg_we/cfg_wdata; the user
// must write it only while no transaction is in flight, which the block does
// not enforce.
module four_level_page_table_walker_core import ptw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_wdata,
  ptw_item_if.sink          item,
  ptw_result_if.source      result
);

  logic  stage_valid;
  logic  stage_ready;
  item_t stage_item;

  ptw_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .stage_valid (stage_valid),
    .stage_item  (stage_item),
    .stage_ready (stage_ready)
  );

  ptw_step u_step (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .stage_valid (stage_valid),
    .stage_item  (stage_item),
    .stage_ready (stage_ready),
    .result      (result)
  );

endmodule
